// File: hw/rtl/spike_rejecting_ema_filter_unit_assert.svh
// ----------------------------------------------------------------------------
// assertion macros for the spike rejecting ema filter unit
// each macro expands to a clocked concurrent assertion, or to nothing
// when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef SPIKE_REJECTING_EMA_FILTER_UNIT_ASSERT_SVH
`define SPIKE_REJECTING_EMA_FILTER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// checked only while out of reset
`define SREMA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// checked on every edge, reset included
`define SREMA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error(msg);

`else

`define SREMA_ASSERT(lbl, prop, msg)
`define SREMA_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// File: hw/rtl/srema_pkg.sv
// ----------------------------------------------------------------------------
// srema_pkg
// field widths, sensor codes, gain limits and register indexes shared by
// the spike rejecting ema filter
// ----------------------------------------------------------------------------
`default_nettype none

package srema_pkg;

    localparam int RAW_W    = 12;
    localparam int TIME_W   = 32;
    localparam int TEMP_W   = 13;
    localparam int ERR_W    = 16;
    localparam int ALPHA_W  = 16;
    localparam int OFFS_W   = 9;
    localparam int JUMP_W   = 12;
    localparam int RUN_W    = 4;
    localparam int WARM_W   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // gain is Q1.15, clamped alpha needs one more bit to hold 1.0
    localparam int ALPHA_SHIFT = 15;
    localparam int ALPHA_CL_W  = ALPHA_SHIFT + 2;

    localparam logic signed [RAW_W-1:0] CODE_DISCONNECT = -12'sd2032;
    localparam logic signed [RAW_W-1:0] CODE_POWERON    = 12'sd1360;

    localparam logic [ALPHA_CL_W-1:0] ALPHA_MIN = 17'd328;
    localparam logic [ALPHA_CL_W-1:0] ALPHA_MAX = 17'd32768;

    localparam logic [RUN_W-1:0] RUN_MAX = 4'd15;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLED      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_OFFSET  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_JUMP     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_OUTLIERS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WARMUP_MS    = 3'd5;

    // register reset values
    localparam logic [ALPHA_W-1:0]        RST_ALPHA        = 16'd3277;
    localparam logic signed [OFFS_W-1:0]  RST_TEMP_OFFSET  = 9'sd0;
    localparam logic [JUMP_W-1:0]         RST_MAX_JUMP     = 12'd80;
    localparam logic [RUN_W-1:0]          RST_MAX_OUTLIERS = 4'd3;
    localparam logic [WARM_W-1:0]         RST_WARMUP_MS    = 16'd2000;

endpackage

`default_nettype wire

// File: hw/rtl/srema_ema.sv
// ----------------------------------------------------------------------------
// srema_ema
// one ema step: clamps the gain and blends a reading into the filter value
// with round half up on the gain product
// ----------------------------------------------------------------------------
`default_nettype none

module srema_ema #(
    parameter int FRAC_BITS = 15
) (
    input  wire logic signed [srema_pkg::RAW_W+FRAC_BITS-1:0] i_filter,
    input  wire logic signed [srema_pkg::RAW_W-1:0]           i_raw,
    input  wire logic        [srema_pkg::ALPHA_W-1:0]         i_alpha,
    output logic      signed [srema_pkg::RAW_W+FRAC_BITS-1:0] o_filter
);

    localparam int FV_W = srema_pkg::RAW_W + FRAC_BITS;
    localparam int D_W  = FV_W + 1;
    localparam int P_W  = D_W + srema_pkg::ALPHA_CL_W + 1;

    logic        [srema_pkg::ALPHA_CL_W-1:0] alpha_cl;
    logic signed [srema_pkg::ALPHA_CL_W:0]   alpha_s;
    logic signed [FV_W-1:0]                  raw_sc;
    logic signed [D_W-1:0]                   diff;
    logic signed [P_W-1:0]                   prod;
    logic signed [P_W-1:0]                   prod_rnd;
    logic signed [P_W-1:0]                   step_full;
    logic signed [D_W-1:0]                   sum;

    always_comb begin
        alpha_cl = {1'b0, i_alpha};
        if (alpha_cl < srema_pkg::ALPHA_MIN) begin
            alpha_cl = srema_pkg::ALPHA_MIN;
        end else if (alpha_cl > srema_pkg::ALPHA_MAX) begin
            alpha_cl = srema_pkg::ALPHA_MAX;
        end
    end

    assign alpha_s = $signed({1'b0, alpha_cl});
    assign raw_sc  = $signed({i_raw, {FRAC_BITS{1'b0}}});
    assign diff    = $signed({raw_sc[FV_W-1], raw_sc}) - $signed({i_filter[FV_W-1], i_filter});

    assign prod      = P_W'(diff) * P_W'(alpha_s);
    assign prod_rnd  = prod + $signed(P_W'(1) <<< (srema_pkg::ALPHA_SHIFT - 1));
    assign step_full = prod_rnd >>> srema_pkg::ALPHA_SHIFT;

    // the step never exceeds the difference, so the sum stays within raw range
    assign sum      = $signed({i_filter[FV_W-1], i_filter}) + step_full[D_W-1:0];
    assign o_filter = sum[FV_W-1:0];

endmodule

`default_nettype wire

// File: hw/rtl/spike_rejecting_ema_filter_unit.sv
// ----------------------------------------------------------------------------
// spike_rejecting_ema_filter_unit
// temperature filter with invalid-code detection, warm-up after reconnect,
// spike rejection and an exponential moving average
// output: a result beat is offered in the cycle after its reading is accepted
// throughput: one reading per cycle while results are taken; o_ready falls while a result waits on i_ready
// reset: synchronous active-low; registers take their reset values, link is up
// ----------------------------------------------------------------------------
`default_nettype none

`include "spike_rejecting_ema_filter_unit_assert.svh"

module spike_rejecting_ema_filter_unit #(
    parameter int FRAC_BITS = 15
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,

    input  wire logic                                  i_valid,
    output logic                                       o_ready,
    input  wire logic signed [srema_pkg::RAW_W-1:0]    i_raw_temp,
    input  wire logic        [srema_pkg::TIME_W-1:0]   i_now_ms,

    output logic                                       o_valid,
    input  wire logic                                  i_ready,
    output logic signed      [srema_pkg::TEMP_W-1:0]   o_temperature,
    output logic                                       o_temp_valid,
    output logic                                       o_connected,
    output logic             [srema_pkg::ERR_W-1:0]    o_fault_cnt,

    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire logic        [srema_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic        [srema_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int FV_W  = srema_pkg::RAW_W + FRAC_BITS;
    localparam int RAW_W = srema_pkg::RAW_W;
    localparam int RUN_W = srema_pkg::RUN_W;
    localparam int ERR_W = srema_pkg::ERR_W;

    // configuration
    logic                                  r_en;
    logic        [srema_pkg::ALPHA_W-1:0]  r_alpha;
    logic signed [srema_pkg::OFFS_W-1:0]   r_offset;
    logic        [srema_pkg::JUMP_W-1:0]   r_max_jump;
    logic        [RUN_W-1:0]               r_max_outliers;
    logic        [srema_pkg::WARM_W-1:0]   r_warmup_ms;

    // filter state, which is also the result of the last accepted beat
    logic                           r_link,   n_link;
    logic [srema_pkg::TIME_W-1:0]   r_ws,     n_ws;
    logic                           r_loaded, n_loaded;
    logic signed [FV_W-1:0]         r_fv,     n_fv;
    logic signed [RAW_W-1:0]        r_prev,   n_prev;
    logic [RUN_W-1:0]               r_run,    n_run;
    logic [ERR_W-1:0]               r_bad,    n_bad;
    logic                           r_out_valid;

    logic                           in_acc;
    logic                           bad_code;
    logic                           warm_done;
    logic [srema_pkg::TIME_W-1:0]   ws_eff;
    logic [srema_pkg::TIME_W-1:0]   elapsed;
    logic                           loaded_eff;
    logic signed [RAW_W:0]          diff;
    logic        [RAW_W:0]          abs_diff;
    logic                           jump;
    logic [RUN_W-1:0]               run_inc;
    logic signed [FV_W-1:0]         ema_fv;
    logic signed [FV_W-1:0]         seed_fv;

    logic signed [FV_W:0]           fv_rnd;
    logic signed [srema_pkg::TEMP_W-1:0] temp_int;
    logic signed [srema_pkg::TEMP_W-1:0] temp_sum;

    assign o_ready     = !r_out_valid || i_ready;
    assign in_acc      = i_valid && o_ready;
    assign o_cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en           <= 1'b0;
            r_alpha        <= srema_pkg::RST_ALPHA;
            r_offset       <= srema_pkg::RST_TEMP_OFFSET;
            r_max_jump     <= srema_pkg::RST_MAX_JUMP;
            r_max_outliers <= srema_pkg::RST_MAX_OUTLIERS;
            r_warmup_ms    <= srema_pkg::RST_WARMUP_MS;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                srema_pkg::CFG_ENABLED:      r_en           <= i_cfg_data[0];
                srema_pkg::CFG_ALPHA:        r_alpha        <= i_cfg_data;
                srema_pkg::CFG_TEMP_OFFSET:  r_offset       <=
                    $signed(i_cfg_data[srema_pkg::OFFS_W-1:0]);
                srema_pkg::CFG_MAX_JUMP:     r_max_jump     <= i_cfg_data[srema_pkg::JUMP_W-1:0];
                srema_pkg::CFG_MAX_OUTLIERS: r_max_outliers <= i_cfg_data[RUN_W-1:0];
                srema_pkg::CFG_WARMUP_MS:    r_warmup_ms    <= i_cfg_data[srema_pkg::WARM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    srema_ema #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ema (
        .i_filter (r_fv),
        .i_raw    (i_raw_temp),
        .i_alpha  (r_alpha),
        .o_filter (ema_fv)
    );

    assign bad_code   = (i_raw_temp == srema_pkg::CODE_DISCONNECT)
                     || (i_raw_temp == srema_pkg::CODE_POWERON);
    // a reconnect restarts the warm-up window at this beat
    assign ws_eff     = r_link ? r_ws : i_now_ms;
    assign loaded_eff = r_link && r_loaded;
    assign elapsed    = i_now_ms - ws_eff;
    assign warm_done  = elapsed >= {{(srema_pkg::TIME_W-srema_pkg::WARM_W){1'b0}}, r_warmup_ms};

    assign diff     = $signed({i_raw_temp[RAW_W-1], i_raw_temp})
                    - $signed({r_prev[RAW_W-1], r_prev});
    assign abs_diff = diff[RAW_W] ? $unsigned(-diff) : $unsigned(diff);
    assign jump     = abs_diff > {1'b0, r_max_jump};
    assign run_inc  = (r_run < srema_pkg::RUN_MAX) ? r_run + 1'b1 : r_run;
    assign seed_fv  = $signed({i_raw_temp, {FRAC_BITS{1'b0}}});

    always_comb begin
        n_link   = r_link;
        n_ws     = r_ws;
        n_loaded = r_loaded;
        n_fv     = r_fv;
        n_prev   = r_prev;
        n_run    = r_run;
        n_bad    = r_bad;
        if (r_en) begin
            if (bad_code) begin
                if (r_bad != {ERR_W{1'b1}}) begin
                    n_bad = r_bad + 1'b1;
                end
                n_link   = 1'b0;
                n_loaded = 1'b0;
            end else begin
                n_link   = 1'b1;
                n_ws     = ws_eff;
                n_loaded = loaded_eff;
                if (warm_done) begin
                    if (!loaded_eff || (jump && run_inc >= r_max_outliers)) begin
                        // seed or reseed
                        n_fv     = seed_fv;
                        n_prev   = i_raw_temp;
                        n_run    = '0;
                        n_loaded = 1'b1;
                    end else if (jump) begin
                        n_run = run_inc;
                    end else begin
                        n_fv   = ema_fv;
                        n_prev = i_raw_temp;
                        n_run  = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link      <= 1'b1;
            r_ws        <= '0;
            r_loaded    <= 1'b0;
            r_fv        <= '0;
            r_prev      <= '0;
            r_run       <= '0;
            r_bad       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_link   <= n_link;
                r_ws     <= n_ws;
                r_loaded <= n_loaded;
                r_fv     <= n_fv;
                r_prev   <= n_prev;
                r_run    <= n_run;
                r_bad    <= n_bad;
            end
            if (in_acc) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result fields come straight from the state; it only moves on a new beat
    assign fv_rnd   = $signed({r_fv[FV_W-1], r_fv}) + $signed((FV_W+1)'(1) <<< (FRAC_BITS - 1));
    assign temp_int = fv_rnd[FRAC_BITS +: srema_pkg::TEMP_W];
    assign temp_sum = temp_int
                    + {{(srema_pkg::TEMP_W-srema_pkg::OFFS_W){r_offset[srema_pkg::OFFS_W-1]}},
                       r_offset};

    assign o_valid       = r_out_valid;
    assign o_temp_valid  = r_link && r_loaded;
    assign o_connected   = r_link;
    assign o_fault_cnt   = r_bad;
    assign o_temperature = o_temp_valid ? temp_sum : '0;

    `SREMA_ASSERT_ALWAYS(a_loaded_needs_link, r_loaded |-> r_link, "loaded without link")
    `SREMA_ASSERT(a_bad_drops_link, in_acc && r_en && bad_code |=> !r_link, "link stayed up")
    `SREMA_ASSERT(a_hold_off, in_acc && !r_en |=> $stable({r_fv, r_bad, r_link}), "state moved")
    `SREMA_ASSERT(a_bad_no_drop, $past(i_rst_n) |-> r_bad >= $past(r_bad), "count fell")

endmodule

`default_nettype wire
